[design/amg_pkg.sv]
// shared widths, register indexes and control types for the adjacency matrix graph query block
`timescale 1ns / 1ps
`default_nettype none
package amg_pkg;

    // fixed field widths
    localparam int VC_W      = 4;   // vertex count, also the common compare width for indices
    localparam int ID_W      = 3;   // vertex index fields
    localparam int WT_W      = 16;  // edge weight
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int DEG_OUT_W = 4;
    localparam int TOT_OUT_W = 5;

    localparam logic [VC_W-1:0] VC_RESET = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_VERTEX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_ROW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_COL    = 2'd3;

    // sequencer to accumulator control
    typedef struct packed {
        logic clear;
        logic sample;
    } acc_ctl_t;

endpackage
`default_nettype wire

[design/adjacency_matrix_graph_query.sv]
// Undirected graph query block: edges load a presence bit matrix, an end beat reports
// the degree of query_vertex, the query pair, the edge count and completeness, and lists
// each missing pair i<j in row-major order, then clears the matrix.
// Input beats: s_tlast low carries an edge, taken with no result; s_tlast high closes
// the run. Only the upper triangle with the diagonal is stored, one bit per pair, in
// a ram of MAX_VERTICES squared entries that the sequencer walks one entry a cycle
// except while the emission pass stalls. An end beat runs one statistics pass, one
// emission pass (one result per missing pair, or a single result with pair_valid low
// when there is none, the final one with m_tlast high) and one clearing pass, stalling
// while m_tready is held low. s_tready is low for all of that time.
// After reset the block clears the whole ram before s_tready rises; configuration
// writes are taken at any time and should be made while idle.
// A result waits in the output register while m_tready is low and the emission pass
// stalls on it; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
module adjacency_matrix_graph_query #(
    parameter int MAX_VERTICES = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [amg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [amg_pkg::VC_W-1:0]          cfg_data,
    // edge stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [amg_pkg::S_TDATA_W-1:0]     s_tdata,  // from_vertex, to_vertex, edge_weight
    input  wire logic                              s_tlast,  // end_of_list
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // degree, pair_is_edge, edge_total, full_graph, pair_valid, pair_low, pair_high
    output logic      [amg_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                   m_tlast   // last
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int DW = $clog2(MAX_VERTICES + 1);
    localparam int CW = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);
    localparam logic [IW-1:0]            LAST_IDX = IW'(MAX_VERTICES - 1);
    localparam logic [AW-1:0]            MAX_A    = AW'(MAX_VERTICES);
    localparam logic [amg_pkg::VC_W-1:0] MAX_C    = amg_pkg::VC_W'(MAX_VERTICES);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_STAT  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_TAIL  = 3'd5;

    function automatic logic [AW-1:0] mem_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        mem_addr = AW'(r) * MAX_A + AW'(c);
    endfunction

    logic [2:0]  state_reg, state_next;
    logic [IW-1:0] r_reg, r_next, c_reg, c_next, tr_reg, tr_next, tc_reg, tc_next;
    logic        tv_reg, tv_next, done_reg, done_next;
    logic [CW-1:0] ecnt_reg, ecnt_next;

    logic [amg_pkg::VC_W-1:0] vcnt_reg, vcnt_next;
    logic [amg_pkg::ID_W-1:0] qv_reg, qv_next, qr_reg, qr_next, qc_reg, qc_next;

    logic                           m_tvalid_reg, m_tvalid_next, m_tlast_reg, m_tlast_next;
    logic [amg_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic          wr_en, wr_data, rd_data;
    logic [AW-1:0] wr_addr, rd_addr;
    amg_pkg::acc_ctl_t ctl;

    logic [DW-1:0] acc_deg;
    logic          acc_pe, acc_hole;
    logic [CW-1:0] acc_tot, acc_miss;

    logic [amg_pkg::VC_W-1:0] n_eff, f_x, t_x, lo_x, hi_x;
    logic          s_acc, out_free, scan_end, hole, stall, edge_ok;
    logic [IW-1:0] step_r, step_c;
    logic          load, load_pv, load_last;
    logic [IW-1:0] load_lo, load_hi;

    amg_ram #(
        .WIDTH (1),
        .DEPTH (MAX_VERTICES * MAX_VERTICES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    amg_acc #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_acc (
        .aclk      (aclk),
        .ctl       (ctl),
        .bit_in    (rd_data),
        .row       (tr_reg),
        .col       (tc_reg),
        .n_eff     (n_eff),
        .q_vertex  (qv_reg),
        .q_row     (qr_reg),
        .q_col     (qc_reg),
        .degree    (acc_deg),
        .pair_edge (acc_pe),
        .total     (acc_tot),
        .missing   (acc_miss),
        .hole      (acc_hole)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        n_eff    = (vcnt_reg > MAX_C) ? MAX_C : vcnt_reg;
        f_x      = amg_pkg::VC_W'(s_tdata[2:0]);
        t_x      = amg_pkg::VC_W'(s_tdata[5:3]);
        lo_x     = (f_x < t_x) ? f_x : t_x;
        hi_x     = (f_x < t_x) ? t_x : f_x;
        edge_ok  = (f_x < n_eff) && (t_x < n_eff);
        scan_end = (r_reg == LAST_IDX) && (c_reg == LAST_IDX);
        // row-major walk over the whole square
        if (c_reg == LAST_IDX) begin
            step_c = '0;
            step_r = r_reg + IW'(1);
        end else begin
            step_c = c_reg + IW'(1);
            step_r = r_reg;
        end
        hole  = tv_reg && acc_hole;
        stall = hole && !out_free;
    end

    always_comb begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        tr_next    = tr_reg;
        tc_next    = tc_reg;
        tv_next    = 1'b0;
        done_next  = done_reg;
        ecnt_next  = ecnt_reg;
        wr_en      = 1'b0;
        wr_addr    = mem_addr(r_reg, c_reg);
        wr_data    = 1'b0;
        rd_addr    = mem_addr(r_reg, c_reg);
        ctl        = '0;
        load       = 1'b0;
        load_pv    = 1'b0;
        load_lo    = tr_reg;
        load_hi    = tc_reg;
        load_last  = 1'b0;

        unique case (state_reg)
            S_CLR: begin
                wr_en  = 1'b1;
                r_next = step_r;
                c_next = step_c;
                if (scan_end) begin
                    r_next     = '0;
                    c_next     = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    if (s_tlast) begin
                        ctl.clear  = 1'b1;
                        state_next = S_STAT;
                    end else if (edge_ok) begin
                        wr_en   = 1'b1;
                        wr_addr = mem_addr(lo_x[IW-1:0], hi_x[IW-1:0]);
                        wr_data = (s_tdata[21:6] != '0);
                    end
                end
            end
            S_STAT: begin
                ctl.sample = tv_reg;
                tv_next    = 1'b1;
                tr_next    = r_reg;
                tc_next    = c_reg;
                r_next     = step_r;
                c_next     = step_c;
                if (scan_end) begin
                    r_next     = '0;
                    c_next     = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                ctl.sample = tv_reg;
                done_next  = 1'b0;
                ecnt_next  = '0;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stall) begin
                    // re-read the held entry so its data stays on the ram output
                    rd_addr = mem_addr(tr_reg, tc_reg);
                    tv_next = 1'b1;
                end else begin
                    if (hole) begin
                        load      = 1'b1;
                        load_pv   = 1'b1;
                        load_last = ((ecnt_reg + CW'(1)) == acc_miss);
                        ecnt_next = ecnt_reg + CW'(1);
                    end
                    if (!done_reg) begin
                        tv_next = 1'b1;
                        tr_next = r_reg;
                        tc_next = c_reg;
                        r_next  = step_r;
                        c_next  = step_c;
                        if (scan_end) begin
                            r_next    = '0;
                            c_next    = '0;
                            done_next = 1'b1;
                        end
                    end else begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                // complete graph: one result with no pair; otherwise straight on to clearing
                if (acc_miss == '0) begin
                    if (out_free) begin
                        load       = 1'b1;
                        load_lo    = '0;
                        load_hi    = '0;
                        load_last  = 1'b1;
                        state_next = S_CLR;
                    end
                end else begin
                    state_next = S_CLR;
                end
            end
            default: begin
                state_next = S_CLR;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'b0,
                             amg_pkg::ID_W'(load_hi),
                             amg_pkg::ID_W'(load_lo),
                             load_pv,
                             (acc_miss == '0),
                             amg_pkg::TOT_OUT_W'(acc_tot),
                             acc_pe,
                             amg_pkg::DEG_OUT_W'(acc_deg)};
            m_tlast_next  = load_last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_comb begin
        vcnt_next = vcnt_reg;
        qv_next   = qv_reg;
        qr_next   = qr_reg;
        qc_next   = qc_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                amg_pkg::REG_VERTEX_COUNT: vcnt_next = cfg_data;
                amg_pkg::REG_QUERY_VERTEX: qv_next   = cfg_data[amg_pkg::ID_W-1:0];
                amg_pkg::REG_QUERY_ROW:    qr_next   = cfg_data[amg_pkg::ID_W-1:0];
                amg_pkg::REG_QUERY_COL:    qc_next   = cfg_data[amg_pkg::ID_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            r_reg        <= '0;
            c_reg        <= '0;
            tv_reg       <= 1'b0;
            done_reg     <= 1'b0;
            ecnt_reg     <= '0;
            vcnt_reg     <= amg_pkg::VC_RESET;
            qv_reg       <= '0;
            qr_reg       <= '0;
            qc_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            tv_reg       <= tv_next;
            done_reg     <= done_next;
            ecnt_reg     <= ecnt_next;
            vcnt_reg     <= vcnt_next;
            qv_reg       <= qv_next;
            qr_reg       <= qr_next;
            qc_reg       <= qc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        tr_reg      <= tr_next;
        tc_reg      <= tc_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

[design/amg_ram.sv]
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module amg_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[design/amg_acc.sv]
// classifies one matrix entry a cycle and accumulates degree, pair, edge and hole counts
`timescale 1ns / 1ps
`default_nettype none
module amg_acc #(
    parameter int MAX_VERTICES = 8
) (
    input  wire logic                                          aclk,
    input  wire amg_pkg::acc_ctl_t                             ctl,
    input  wire logic                                          bit_in,
    input  wire logic [$clog2(MAX_VERTICES)-1:0]               row,
    input  wire logic [$clog2(MAX_VERTICES)-1:0]               col,
    input  wire logic [amg_pkg::VC_W-1:0]                      n_eff,
    input  wire logic [amg_pkg::ID_W-1:0]                      q_vertex,
    input  wire logic [amg_pkg::ID_W-1:0]                      q_row,
    input  wire logic [amg_pkg::ID_W-1:0]                      q_col,
    output logic      [$clog2(MAX_VERTICES+1)-1:0]             degree,
    output logic                                               pair_edge,
    output logic      [$clog2(MAX_VERTICES*(MAX_VERTICES-1)/2+1)-1:0] total,
    output logic      [$clog2(MAX_VERTICES*(MAX_VERTICES-1)/2+1)-1:0] missing,
    output logic                                               hole
);

    localparam int DW = $clog2(MAX_VERTICES + 1);
    localparam int CW = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);

    logic [amg_pkg::VC_W-1:0] row_x, col_x, qv_x, qr_x, qc_x, pq_lo, pq_hi;
    logic in_tri, upper, deg_hit, pe_hit;

    logic [DW-1:0] deg_reg;
    logic          pe_reg;
    logic [CW-1:0] tot_reg, miss_reg;

    always_comb begin
        row_x   = amg_pkg::VC_W'(row);
        col_x   = amg_pkg::VC_W'(col);
        qv_x    = amg_pkg::VC_W'(q_vertex);
        qr_x    = amg_pkg::VC_W'(q_row);
        qc_x    = amg_pkg::VC_W'(q_col);
        pq_lo   = (qr_x < qc_x) ? qr_x : qc_x;
        pq_hi   = (qr_x < qc_x) ? qc_x : qr_x;
        // edges only ever set bits in the upper triangle with the diagonal
        in_tri  = (row_x <= col_x) && (col_x < n_eff);
        upper   = (row_x < col_x) && (col_x < n_eff);
        deg_hit = bit_in && in_tri && (qv_x < n_eff) && ((row_x == qv_x) || (col_x == qv_x));
        pe_hit  = bit_in && (qr_x < n_eff) && (qc_x < n_eff)
                  && (row_x == pq_lo) && (col_x == pq_hi);
        hole    = upper && !bit_in;
    end

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            deg_reg  <= '0;
            pe_reg   <= 1'b0;
            tot_reg  <= '0;
            miss_reg <= '0;
        end else if (ctl.sample) begin
            deg_reg  <= deg_reg + DW'(deg_hit);
            pe_reg   <= pe_reg | pe_hit;
            tot_reg  <= tot_reg + CW'(upper && bit_in);
            miss_reg <= miss_reg + CW'(hole);
        end
    end

    assign degree    = deg_reg;
    assign pair_edge = pe_reg;
    assign total     = tot_reg;
    assign missing   = miss_reg;

endmodule
`default_nettype wire
